// ===== rtl/lpe_pkg.sv =====
package lpe_pkg;

   localparam int MAX_NODES = 16;
   localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int SUM_W     = 32 + CNT_W + 1;
   localparam int DIV_STEPS = 32;

   localparam logic [4:0] NODE_COUNT_RESET = 5'd9;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_COINCIDENT = 2'd1,
      STATUS_SATURATED  = 2'd2
   } status_type;

endpackage

// ===== rtl/lpe_channels.sv =====
interface lpe_req_if import lpe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [3:0]         node_index;
   logic signed [31:0] node_x;
   logic signed [31:0] node_y;
   logic signed [31:0] eval_point;

   modport source (output valid, command, node_index, node_x, node_y, eval_point,
                   input ready);
   modport sink   (input valid, command, node_index, node_x, node_y, eval_point,
                   output ready);
endinterface

interface lpe_rsp_if import lpe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

// ===== rtl/lpe_ram.sv =====
module lpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/lagrange_polynomial_evaluator.sv =====
// Load word: acknowledged in the cycle after acceptance.
// Evaluate word: a coincident node pair skips a factor's multiply and divide, and a
// quotient that overflows skips the divide. Otherwise each factor runs one shared
// 32x32 multiplier and a 32-step restoring divider.
// One word is in flight at a time; ready returns when the result is registered and the response is taken.
// Synchronous active-high reset clears the sequencer, the result valid and
// node_count (to 9); node storage is undefined until loaded.
module lagrange_polynomial_evaluator import lpe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lpe_req_if.sink    req_ch,
   lpe_rsp_if.source  rsp_ch,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_RD_I   = 10'b0000000010,
      ST_LD_I   = 10'b0000000100,
      ST_NEXT_J = 10'b0000001000,
      ST_LD_J   = 10'b0000010000,
      ST_MUL    = 10'b0000100000,
      ST_DIVCHK = 10'b0001000000,
      ST_DIV    = 10'b0010000000,
      ST_APPLY  = 10'b0100000000,
      ST_FINISH = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         node_count_ff, node_count_in;
   logic signed [31:0] x_pt_ff, x_pt_in;
   logic [CNT_W-1:0]   n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic signed [31:0] xi_ff, xi_in, term_ff, term_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic               coinc_ff, coinc_in, sat_ff, sat_in;
   logic [31:0]        mt_ff, mt_in, mn_ff, mn_in, md_ff, md_in;
   logic               neg_ff, neg_in, big_ff, big_in;
   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               accept;
   logic               wr_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [31:0]        x_rd_data_ff, y_rd_data_ff;
   logic signed [32:0] num, den, term_ext;
   logic [32:0]        div_cat;
   logic               div_ge;
   logic [CNT_W-1:0]   n_eval;

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign wr_en        = accept && (req_ch.command == CMD_LOAD)
                         && (32'(req_ch.node_index) < MAX_NODES);

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;

   assign rd_addr = (state_ff == ST_RD_I) ? i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];

   lpe_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_x_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (IDX_W'(req_ch.node_index)),
      .wr_data    (req_ch.node_x),
      .rd_addr    (rd_addr),
      .rd_data_ff (x_rd_data_ff)
   );

   lpe_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_y_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (IDX_W'(req_ch.node_index)),
      .wr_data    (req_ch.node_y),
      .rd_addr    (rd_addr),
      .rd_data_ff (y_rd_data_ff)
   );

   assign n_eval   = (32'(node_count_ff) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count_ff);
   assign num      = {x_pt_ff[31], x_pt_ff} - {x_rd_data_ff[31], x_rd_data_ff};
   assign den      = {xi_ff[31], xi_ff} - {x_rd_data_ff[31], x_rd_data_ff};
   assign term_ext = {term_ff[31], term_ff};
   assign div_cat  = {rem_ff, quo_ff[31]};
   assign div_ge   = div_cat >= {1'b0, md_ff};

   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      x_pt_in       = x_pt_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      xi_in         = xi_ff;
      term_in       = term_ff;
      sum_in        = sum_ff;
      coinc_in      = coinc_ff;
      sat_in        = sat_ff;
      mt_in         = mt_ff;
      mn_in         = mn_ff;
      md_in         = md_ff;
      neg_in        = neg_ff;
      big_in        = big_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.command == CMD_LOAD || n_eval == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_OK;
               end else begin
                  x_pt_in  = req_ch.eval_point;
                  n_in     = n_eval;
                  i_in     = '0;
                  sum_in   = '0;
                  coinc_in = 1'b0;
                  sat_in   = 1'b0;
                  state_in = ST_RD_I;
               end
            end
         end
         ST_RD_I: begin
            state_in = ST_LD_I;
         end
         ST_LD_I: begin
            xi_in    = x_rd_data_ff;
            term_in  = y_rd_data_ff;
            j_in     = '0;
            state_in = ST_NEXT_J;
         end
         ST_NEXT_J: begin
            if (j_ff == n_ff) begin
               sum_in = sum_ff + SUM_W'(term_ext);
               i_in   = i_ff + 1'b1;
               j_in   = '0;
               state_in = (i_ff + 1'b1 == n_ff) ? ST_FINISH : ST_RD_I;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = ST_LD_J;
            end
         end
         ST_LD_J: begin
            if (den == '0) begin
               coinc_in = 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = ST_NEXT_J;
            end else begin
               mt_in    = term_ff[31] ? 32'(-term_ext) : term_ff;
               mn_in    = num[32] ? 32'(-num) : num[31:0];
               md_in    = den[32] ? 32'(-den) : den[31:0];
               neg_in   = term_ff[31] ^ num[32] ^ den[32];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mt_ff * mn_ff;
            state_in = ST_DIVCHK;
         end
         ST_DIVCHK: begin
            big_in     = prod_ff[63:32] >= md_ff;
            rem_in     = prod_ff[63:32];
            quo_in     = prod_ff[31:0];
            div_cnt_in = '0;
            state_in   = (prod_ff[63:32] >= md_ff) ? ST_APPLY : ST_DIV;
         end
         ST_DIV: begin
            rem_in     = div_ge ? 32'(div_cat - {1'b0, md_ff}) : div_cat[31:0];
            quo_in     = {quo_ff[30:0], div_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (neg_ff && (big_ff || quo_ff > 32'h8000_0000)) begin
               term_in = 32'sh8000_0000;
               sat_in  = 1'b1;
            end else if (!neg_ff && (big_ff || quo_ff[31])) begin
               term_in = 32'sh7fff_ffff;
               sat_in  = 1'b1;
            end else begin
               term_in = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_NEXT_J;
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (coinc_ff) begin
               rsp_value_in  = '0;
               rsp_status_in = STATUS_COINCIDENT;
            end else if (sum_ff > SUM_W'(32'sh7fff_ffff)) begin
               rsp_value_in  = 32'sh7fff_ffff;
               rsp_status_in = STATUS_SATURATED;
            end else if (sum_ff < SUM_W'(32'sh8000_0000)) begin
               rsp_value_in  = 32'sh8000_0000;
               rsp_status_in = STATUS_SATURATED;
            end else begin
               rsp_value_in  = sum_ff[31:0];
               rsp_status_in = sat_ff ? STATUS_SATURATED : STATUS_OK;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_pt_ff       <= x_pt_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      xi_ff         <= xi_in;
      term_ff       <= term_in;
      sum_ff        <= sum_in;
      coinc_ff      <= coinc_in;
      sat_ff        <= sat_in;
      mt_ff         <= mt_in;
      mn_ff         <= mn_in;
      md_ff         <= md_in;
      neg_ff        <= neg_in;
      big_ff        <= big_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_coinc_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_COINCIDENT) |-> (rsp_value_ff == '0))
      else $error("coincident result carries nonzero value");

   a_apply_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> ($past(state_ff) == ST_DIV || $past(state_ff) == ST_DIVCHK))
      else $error("term update without divide");

   a_loop_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT_J) |-> (i_ff < n_ff && j_ff <= n_ff))
      else $error("node loop out of range");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff != 2'd3))
      else $error("invalid status code");

endmodule
